// ----- rtl/ipd_pkg.sv -----
package ipd_pkg;

    // interval field width default and limit register width
    localparam int INTERVAL_BITS_DEF = 20;
    localparam int LIMIT_W           = 20;

    // register indexes on the configuration port
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH = 8'd1;

    localparam logic [LIMIT_W-1:0] ZERO_LOW_RST  = 20'd1000;
    localparam logic [LIMIT_W-1:0] ZERO_HIGH_RST = 20'd1500;

    // item kinds carried in tuser
    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // frame bit positions
    localparam logic [4:0] EDGE_MAX       = 5'd31;
    localparam logic [4:0] FIRST_BIT_EDGE = 5'd17;
    localparam logic [4:0] LAST_BIT_EDGE  = 5'd24;

    // command queue between classifier and LED controller
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // button codes
    localparam logic [7:0] BTN_RED   = 8'd84;
    localparam logic [7:0] BTN_GREEN = 8'd22;
    localparam logic [7:0] BTN_BLUE  = 8'd21;
    localparam logic [7:0] BTN_PAT0  = 8'd80;
    localparam logic [7:0] BTN_PAT1  = 8'd18;
    localparam logic [7:0] BTN_PAT2  = 8'd17;
    localparam logic [7:0] BTN_PAT3  = 8'd76;
    localparam logic [7:0] BTN_PAT4  = 8'd14;
    localparam logic [7:0] BTN_PAT5  = 8'd13;
    localparam logic [7:0] BTN_PAT6  = 8'd28;

    // result beat layout
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic       valid;
        logic [7:0] command;
    } cmd_beat_t;

endpackage

// ----- rtl/ipd_front.sv -----
module ipd_front #(
    parameter int INTERVAL_BITS = ipd_pkg::INTERVAL_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_accept,
    input  logic                            item_kind,
    input  logic [INTERVAL_BITS-1:0]        item_interval,
    input  logic                            cfg_write,
    input  logic [ipd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ipd_pkg::LIMIT_W-1:0]     cfg_data,
    output ipd_pkg::cmd_beat_t              push
);

    localparam int CMP_W = (INTERVAL_BITS > ipd_pkg::LIMIT_W) ? INTERVAL_BITS
                                                                : ipd_pkg::LIMIT_W;

    logic [ipd_pkg::LIMIT_W-1:0] zero_low_reg, zero_high_reg;
    logic                        armed_reg, armed_next;
    logic [4:0]                  edge_count_reg, edge_count_next;
    logic [7:0]                  command_bits_reg, command_bits_next;

    logic [CMP_W-1:0] ivl_ext, low_ext, high_ext;
    logic             is_zero;
    logic             in_field;
    logic [2:0]       bit_sel;
    logic [4:0]       bit_off;

    // limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_low_reg  <= ipd_pkg::ZERO_LOW_RST;
            zero_high_reg <= ipd_pkg::ZERO_HIGH_RST;
        end else if (cfg_write) begin
            if (cfg_index == ipd_pkg::REG_ZERO_LOW)  zero_low_reg  <= cfg_data;
            if (cfg_index == ipd_pkg::REG_ZERO_HIGH) zero_high_reg <= cfg_data;
        end
    end

    // classify the interval against the zero window
    always_comb begin
        ivl_ext  = CMP_W'(item_interval);
        low_ext  = CMP_W'(zero_low_reg);
        high_ext = CMP_W'(zero_high_reg);
        is_zero  = (ivl_ext >= low_ext) && (ivl_ext <= high_ext);
        in_field = (edge_count_reg >= ipd_pkg::FIRST_BIT_EDGE) &&
                   (edge_count_reg <= ipd_pkg::LAST_BIT_EDGE);
        bit_off  = edge_count_reg - ipd_pkg::FIRST_BIT_EDGE;
        bit_sel  = bit_off[2:0];
    end

    // frame state update
    always_comb begin
        armed_next        = armed_reg;
        edge_count_next   = edge_count_reg;
        command_bits_next = command_bits_reg;
        push.valid        = 1'b0;
        push.command      = command_bits_reg;
        if (item_accept) begin
            if (item_kind == ipd_pkg::KIND_TIMEOUT) begin
                push.valid      = 1'b1;
                armed_next      = 1'b0;
                edge_count_next = '0;
            end else if (!armed_reg) begin
                armed_next = 1'b1;
            end else begin
                if (in_field) command_bits_next[bit_sel] = !is_zero;
                if (edge_count_reg != ipd_pkg::EDGE_MAX)
                    edge_count_next = edge_count_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg        <= 1'b0;
            edge_count_reg   <= '0;
            command_bits_reg <= '1;
        end else begin
            armed_reg        <= armed_next;
            edge_count_reg   <= edge_count_next;
            command_bits_reg <= command_bits_next;
        end
    end

endmodule

// ----- rtl/ipd_cmd_fifo.sv -----
module ipd_cmd_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  ipd_pkg::cmd_beat_t push,
    input  logic               pop,
    output ipd_pkg::cmd_beat_t head,
    output logic               full
);

    localparam int DEPTH = ipd_pkg::QUEUE_DEPTH;
    localparam int PW    = ipd_pkg::QPTR_W;

    logic [7:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full         = (count_reg == (PW+1)'(DEPTH));
    assign head.valid   = (count_reg != '0);
    assign head.command = mem[rd_ptr_reg];
    assign do_push      = push.valid && !full;
    assign do_pop       = pop && head.valid;

    always_comb begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (PW+1)'(1);
            2'b01:   count_next = count_reg - (PW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push.command;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/ipd_back.sv -----
module ipd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  ipd_pkg::cmd_beat_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_command,
    output logic [2:0]         out_rgb,
    output logic [7:0]         out_led
);

    logic [9:0] flags_reg, flags_next;
    logic [2:0] rgb_reg, rgb_next;
    logic [7:0] pattern_reg, pattern_next;
    logic       out_valid_reg;
    logic [7:0] out_command_reg;
    logic [2:0] out_rgb_reg;
    logic [7:0] out_led_reg;

    assign pop         = head.valid && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_command = out_command_reg;
    assign out_rgb     = out_rgb_reg;
    assign out_led     = out_led_reg;

    // button action on the queue head
    always_comb begin
        flags_next   = flags_reg;
        rgb_next     = rgb_reg;
        pattern_next = pattern_reg;
        unique case (head.command)
            ipd_pkg::BTN_RED: begin
                flags_next[0] = !flags_reg[0];
                rgb_next[0]   = flags_reg[0];
            end
            ipd_pkg::BTN_GREEN: begin
                flags_next[1] = !flags_reg[1];
                rgb_next[1]   = flags_reg[1];
            end
            ipd_pkg::BTN_BLUE: begin
                flags_next[2] = !flags_reg[2];
                rgb_next[2]   = flags_reg[2];
            end
            ipd_pkg::BTN_PAT0: begin
                flags_next[3] = !flags_reg[3];
                pattern_next  = flags_reg[3] ? 8'h00 : 8'h55;
            end
            ipd_pkg::BTN_PAT1: begin
                flags_next[4] = !flags_reg[4];
                pattern_next  = flags_reg[4] ? 8'h00 : 8'hDB;
            end
            ipd_pkg::BTN_PAT2: begin
                flags_next[5] = !flags_reg[5];
                pattern_next  = flags_reg[5] ? 8'h00 : 8'hC3;
            end
            ipd_pkg::BTN_PAT3: begin
                flags_next[6] = !flags_reg[6];
                pattern_next  = flags_reg[6] ? 8'h00 : 8'h18;
            end
            ipd_pkg::BTN_PAT4: begin
                flags_next[7] = !flags_reg[7];
                pattern_next  = flags_reg[7] ? 8'h00 : 8'h99;
            end
            ipd_pkg::BTN_PAT5: begin
                flags_next[8] = !flags_reg[8];
                pattern_next  = flags_reg[8] ? 8'h00 : 8'h66;
            end
            ipd_pkg::BTN_PAT6: begin
                flags_next[9] = !flags_reg[9];
                pattern_next  = flags_reg[9] ? 8'h00 : 8'hFF;
            end
            default: ;
        endcase
    end

    // LED state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg   <= '0;
            rgb_reg     <= '1;
            pattern_reg <= '0;
        end else if (pop) begin
            flags_reg   <= flags_next;
            rgb_reg     <= rgb_next;
            pattern_reg <= pattern_next;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= pop || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_command_reg <= head.command;
            out_rgb_reg     <= rgb_next;
            out_led_reg     <= pattern_next;
        end
    end

endmodule

// ----- rtl/ir_pulse_distance_decoder_core.sv -----
// Pulse-distance infrared remote decoder with an LED controller behind it. Each
// input beat is either an edge (tuser low, tdata = ticks since the previous
// edge) or a frame timeout (tuser high). The first edge arms the frame; the 18th
// to 25th edges after the arming edge deliver command bits 0 to 7, a bit being 0
// when its interval lies inside [zero_low_limit, zero_high_limit]. A timeout
// hands the command byte to the LED controller, which toggles the button's flag
// and emits one result beat with the command, the active-low RGB pins and the
// LED bank after the command has passed the queue and the output register.
// The block takes one beat per cycle. Any input beat, edge or timeout, stalls
// while the four-entry command queue between classifier and LED controller
// is full, which happens only while the result register is held by m_tready low.
module ir_pulse_distance_decoder_core #(
    parameter int INTERVAL_BITS = ipd_pkg::INTERVAL_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((INTERVAL_BITS+7)/8)*8-1:0] s_tdata, // interval
    input  logic                            s_tuser,    // kind
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ipd_pkg::M_TDATA_W-1:0]   m_tdata,    // command, rgb_pins, led_bank
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ipd_pkg::LIMIT_W-1:0]     cfg_data
);

    ipd_pkg::cmd_beat_t push, head;
    logic               q_full, pop;
    logic               item_accept;
    logic [7:0]         res_command;
    logic [2:0]         res_rgb;
    logic [7:0]         res_led;

    assign cfg_ready   = 1'b1;
    assign s_tready    = !q_full;
    assign item_accept = s_tvalid && s_tready;
    assign m_tdata     = {5'd0, res_led, res_rgb, res_command};

    ipd_front #(
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_accept  (item_accept),
        .item_kind    (s_tuser),
        .item_interval(s_tdata[INTERVAL_BITS-1:0]),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push)
    );

    ipd_cmd_fifo u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .full   (q_full)
    );

    ipd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_command(res_command),
        .out_rgb    (res_rgb),
        .out_led    (res_led)
    );

endmodule

// ----- rtl/ipd_checker.sv -----
module ipd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ipd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          cfg_ready
);

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // no result beat right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // padding bits above the led bank stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:19] == 5'd0)
        else $error("result padding not zero");

    // configuration port never back-pressures
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind ir_pulse_distance_decoder_core ipd_checker u_ipd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_ready(cfg_ready)
);

// ----- verif/tb_ir_pulse_distance_decoder_core.sv -----
module tb_ir_pulse_distance_decoder_core;
    import ipd_pkg::*;

    localparam int IVL_W         = INTERVAL_BITS_DEF;
    localparam int S_TDATA_W     = ((IVL_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [IVL_W-1:0] IVL_MAX = '1;

    // button codes, red first
    localparam logic [9:0][7:0] BUTTONS = {BTN_PAT6, BTN_PAT5, BTN_PAT4, BTN_PAT3, BTN_PAT2,
                                           BTN_PAT1, BTN_PAT0, BTN_BLUE, BTN_GREEN, BTN_RED};

    typedef struct packed {
        logic             kind;
        logic [IVL_W-1:0] interval;
    } ir_beat_t;

    typedef struct packed {
        logic [7:0] command;
        logic [2:0] rgb_pins;
        logic [7:0] led_bank;
    } led_report_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // interval
    logic                   s_tuser   = KIND_EDGE;   // kind
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // command, rgb_pins, led_bank
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_ZERO_LOW;
    logic [LIMIT_W-1:0]     cfg_data  = '0;

    ir_pulse_distance_decoder_core #(
        .INTERVAL_BITS(IVL_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // decoder state as the testbench sees it
    logic [LIMIT_W-1:0] lim_lo      = ZERO_LOW_RST;
    logic [LIMIT_W-1:0] lim_hi      = ZERO_HIGH_RST;
    logic               frame_armed = 1'b0;
    logic [4:0]         edge_cnt    = '0;
    logic [7:0]         cmd_bits    = 8'hFF;
    logic [9:0]         btn_flags   = '0;
    logic [2:0]         rgb_level   = 3'b111;
    logic [7:0]         led_level   = '0;

    ir_beat_t    ir_beats_todo[$];
    led_report_t led_reports_due[$];
    ir_beat_t    cur_beat;
    logic        beat_pending   = 1'b0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_queued   = 0;
    int          errors         = 0;

    // advance the decoder state by one accepted beat
    task automatic decode_ir_beat(input ir_beat_t b);
        int         idx;
        logic [7:0] pat;
        logic       turn_on;
        idx = -1;
        pat = 8'h00;
        if (b.kind == KIND_EDGE) begin
            if (!frame_armed) begin
                frame_armed = 1'b1;
            end else begin
                if (edge_cnt >= FIRST_BIT_EDGE && edge_cnt <= LAST_BIT_EDGE) begin
                    cmd_bits[3'(edge_cnt - FIRST_BIT_EDGE)] =
                        !(b.interval >= lim_lo && b.interval <= lim_hi);
                end
                if (edge_cnt != EDGE_MAX) edge_cnt++;
            end
        end else begin
            frame_armed = 1'b0;
            edge_cnt    = '0;
            case (cmd_bits)
                BTN_RED:   idx = 0;
                BTN_GREEN: idx = 1;
                BTN_BLUE:  idx = 2;
                BTN_PAT0: begin idx = 3; pat = 8'h55; end
                BTN_PAT1: begin idx = 4; pat = 8'hDB; end
                BTN_PAT2: begin idx = 5; pat = 8'hC3; end
                BTN_PAT3: begin idx = 6; pat = 8'h18; end
                BTN_PAT4: begin idx = 7; pat = 8'h99; end
                BTN_PAT5: begin idx = 8; pat = 8'h66; end
                BTN_PAT6: begin idx = 9; pat = 8'hFF; end
                default:   idx = -1;
            endcase
            if (idx >= 0) begin
                turn_on        = !btn_flags[idx];
                btn_flags[idx] = turn_on;
                // colors are active low
                if (idx < 3) rgb_level[idx] = !turn_on;
                else         led_level = turn_on ? pat : 8'h00;
            end
            led_reports_due.push_back('{cmd_bits, rgb_level, led_level});
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            beat_pending = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_ir_beat(cur_beat);
                beat_pending = 1'b0;
            end
            if (!beat_pending) begin
                if (ir_beats_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = ir_beats_todo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(cur_beat.interval);
                    s_tuser  <= cur_beat.kind;
                    beat_pending = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            if (errors < 50)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge aclk) begin : result_mon
        led_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (led_reports_due.size() == 0) begin
                    if (errors < 50)
                        $display("%0t: result beat with none due, expected nothing, got %h",
                                 $time, m_tdata);
                    errors++;
                end else begin
                    want = led_reports_due.pop_front();
                    check_field("command", want.command, m_tdata[7:0]);
                    check_field("rgb_pins", want.rgb_pins, m_tdata[10:8]);
                    check_field("led_bank", want.led_bank, m_tdata[18:11]);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_beat(input logic kind, input logic [IVL_W-1:0] ivl);
        ir_beats_todo.push_back('{kind, ivl});
        items_queued++;
    endtask

    function automatic logic [IVL_W-1:0] any_interval();
        return ($urandom_range(1) == 1) ? IVL_W'($urandom_range(3000)) : IVL_W'($urandom);
    endfunction

    // interval that decodes to the wanted bit, hitting the limits now and then
    function automatic logic [IVL_W-1:0] bit_interval(input logic one);
        logic at_limit;
        at_limit = ($urandom_range(3) == 0);
        if (!one && lim_lo <= lim_hi)
            return at_limit ? (($urandom_range(1) == 1) ? lim_lo : lim_hi)
                            : IVL_W'($urandom_range(lim_hi, lim_lo));
        if (one && lim_lo != 0 && (lim_hi == IVL_MAX || $urandom_range(1) == 1))
            return at_limit ? IVL_W'(lim_lo - 1) : IVL_W'($urandom_range(lim_lo - 1, 0));
        if (one && lim_hi != IVL_MAX)
            return at_limit ? IVL_W'(lim_hi + 1) : IVL_W'($urandom_range(IVL_MAX, lim_hi + 1));
        return any_interval();
    endfunction

    // arming edge, header edges, eight command bits, trailing edges, timeout
    task automatic queue_frame(input logic [7:0] code, input int extra);
        push_beat(KIND_EDGE, any_interval());
        repeat (FIRST_BIT_EDGE) push_beat(KIND_EDGE, any_interval());
        for (int i = 0; i < 8; i++) push_beat(KIND_EDGE, bit_interval(code[i]));
        repeat (extra) push_beat(KIND_EDGE, any_interval());
        push_beat(KIND_TIMEOUT, any_interval());
    endtask

    task automatic queue_random_traffic(input int count);
        int         stop_at;
        logic [7:0] code;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            code = ($urandom_range(9) < 7) ? BUTTONS[$urandom_range(9)] : 8'($urandom);
            case ($urandom_range(19))
                0, 1: push_beat(KIND_TIMEOUT, any_interval());
                2, 3: begin
                    // loose noise
                    repeat ($urandom_range(8, 1))
                        push_beat(($urandom_range(3) == 0) ? KIND_TIMEOUT : KIND_EDGE,
                                  any_interval());
                end
                4, 5: begin
                    // truncated frame, some bits kept from before
                    repeat ($urandom_range(25, 1)) push_beat(KIND_EDGE, any_interval());
                    push_beat(KIND_TIMEOUT, any_interval());
                end
                6: queue_frame(code, $urandom_range(14, 6));   // runs the counter into saturation
                default: queue_frame(code, $urandom_range(2));
            endcase
        end
    endtask

    task automatic wait_idle();
        while (ir_beats_todo.size() != 0 || beat_pending || led_reports_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [LIMIT_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_ZERO_LOW) lim_lo = val;
        else                     lim_hi = val;
    endtask

    task automatic start_phase(input int send_pct, input int recv_pct,
                               input logic [LIMIT_W-1:0] lo, input logic [LIMIT_W-1:0] hi);
        wait_idle();
        write_limit(REG_ZERO_LOW, lo);
        write_limit(REG_ZERO_HIGH, hi);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        start_phase(0, 0, 20'd1000, 20'd1500);
        // timeout with nothing armed, then a red frame built on the limits
        push_beat(KIND_TIMEOUT, IVL_MAX);
        push_beat(KIND_EDGE, '0);
        for (int i = 0; i < 17; i++) push_beat(KIND_EDGE, (i % 2 == 1) ? IVL_MAX : '0);
        for (int i = 0; i < 8; i++)
            push_beat(KIND_EDGE,
                      BTN_RED[i] ? ((i % 2 == 1) ? IVL_W'(lim_hi + 1) : IVL_W'(lim_lo - 1))
                                 : ((i % 2 == 1) ? IVL_W'(lim_hi) : IVL_W'(lim_lo)));
        push_beat(KIND_TIMEOUT, '0);
        // bare timeout repeats the kept command
        push_beat(KIND_TIMEOUT, '0);
        queue_random_traffic(320);

        start_phase(49, 0, 20'd0, 20'd700);
        queue_random_traffic(330);

        start_phase(0, 49, 20'd400000, IVL_MAX);
        queue_random_traffic(160);
        wait_idle();
        queue_random_traffic(170);

        // inverted limits: every bit decodes as one
        start_phase(8, 8, 20'd2000, 20'd1000);
        queue_random_traffic(250);

        start_phase(0, 0, 20'd0, IVL_MAX);
        queue_random_traffic(150);

        start_phase(8, 8, 20'd5000, 20'd5000);
        queue_random_traffic(300);

        wait_idle();
        if (errors == 0) begin
            $display("ir_pulse_distance_decoder_core test passed");
        end else begin
            $display("ir_pulse_distance_decoder_core test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("ir_pulse_distance_decoder_core test failed");
        $finish;
    end

endmodule
